// ===== rtl/sh64_pkg.sv =====
package sh64_pkg;
	localparam logic [63:0] KEY1 = 64'hB88C6B5A7D3C6D49;
	localparam logic [63:0] KEY2 = 64'h34827E1F6C4B5A3D;
	localparam logic [63:0] KEY3 = 64'h9A7D8C6B5F4E3D2C;
	localparam logic [63:0] KEY4 = 64'h1B3C5D7E9F0A2B4C;
	localparam logic [63:0] SKEY1 = 64'h0000000034827E1F;
	localparam logic [63:0] SKEY2 = 64'h000000009A7D8C6B;
	localparam logic [63:0] SKEY3 = 64'h000000001B3C5D7E;
	localparam logic [63:0] SKEY4 = 64'h00000000B88C6B5A;

	// Datapath operations issued by the controller.
	localparam logic [3:0] OP_LOAD   = 4'd0;
	localparam logic [3:0] OP_ACCPRE = 4'd1;
	localparam logic [3:0] OP_ACCPOST = 4'd2;
	localparam logic [3:0] OP_MERGE  = 4'd3;
	localparam logic [3:0] OP_C8PRE  = 4'd4;
	localparam logic [3:0] OP_C8POST = 4'd5;
	localparam logic [3:0] OP_C8MIX  = 4'd6;
	localparam logic [3:0] OP_C4PRE  = 4'd7;
	localparam logic [3:0] OP_C4POST = 4'd8;
	localparam logic [3:0] OP_C4MIX  = 4'd9;
	localparam logic [3:0] OP_BYTE   = 4'd10;
	localparam logic [3:0] OP_FIN    = 4'd11;
	localparam logic [3:0] OP_RESET  = 4'd12;
	localparam logic [3:0] OP_NONE   = 4'd13;

	// mstep selects the partial product of a multiply; wr marks the cycle
	// in which the operation writes its destination.
	typedef struct packed {
		logic [3:0] op;
		logic [1:0] lane;
		logic [2:0] fin_step;
		logic [1:0] mstep;
		logic       wr;
	} cmd_t;

	typedef struct packed {
		logic       stripe;
		logic       last;
		logic       has8;
		logic       has4;
		logic [1:0] nbytes;
	} status_t;
endpackage

// ===== rtl/sh64_ctrl.sv =====
module sh64_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sh64_pkg::status_t   st,
	output sh64_pkg::cmd_t      cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_APRE = 4'd1;
	localparam logic [3:0] S_APST = 4'd2;
	localparam logic [3:0] S_MRG  = 4'd3;
	localparam logic [3:0] S_8A   = 4'd4;
	localparam logic [3:0] S_8B   = 4'd5;
	localparam logic [3:0] S_8C   = 4'd6;
	localparam logic [3:0] S_4A   = 4'd7;
	localparam logic [3:0] S_4B   = 4'd8;
	localparam logic [3:0] S_4C   = 4'd9;
	localparam logic [3:0] S_BYT  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0] state_q;
	logic [1:0] lane_q;
	logic [1:0] cnt_q;
	logic [2:0] fin_q;
	logic [1:0] mstep_q;
	logic       mul_op;
	logic       step_done;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// A multiply is built from partial products on the shared 32x32 multiplier.
	always_comb begin
		case (state_q)
			S_APRE: mul_op = st.stripe;
			S_APST, S_8A, S_8B, S_8C, S_4A, S_4B, S_4C, S_BYT: mul_op = 1'b1;
			S_FIN: mul_op = (fin_q inside {3'd0, 3'd2});
			default: mul_op = 1'b0;
		endcase
	end

	assign step_done = !mul_op || (mstep_q == 2'd2);

	always_comb begin
		cmd.lane = lane_q;
		cmd.fin_step = fin_q;
		cmd.mstep = mstep_q;
		cmd.wr = step_done;
		case (state_q)
			S_IDLE: cmd.op = in_valid ? sh64_pkg::OP_LOAD : sh64_pkg::OP_NONE;
			S_APRE: cmd.op = st.stripe ? sh64_pkg::OP_ACCPRE : sh64_pkg::OP_NONE;
			S_APST: cmd.op = sh64_pkg::OP_ACCPOST;
			S_MRG:  cmd.op = sh64_pkg::OP_MERGE;
			S_8A:   cmd.op = sh64_pkg::OP_C8PRE;
			S_8B:   cmd.op = sh64_pkg::OP_C8POST;
			S_8C:   cmd.op = sh64_pkg::OP_C8MIX;
			S_4A:   cmd.op = sh64_pkg::OP_C4PRE;
			S_4B:   cmd.op = sh64_pkg::OP_C4POST;
			S_4C:   cmd.op = sh64_pkg::OP_C4MIX;
			S_BYT:  cmd.op = sh64_pkg::OP_BYTE;
			S_FIN:  cmd.op = sh64_pkg::OP_FIN;
			S_OUT:  cmd.op = out_ready ? sh64_pkg::OP_RESET : sh64_pkg::OP_NONE;
			default: cmd.op = sh64_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lane_q <= '0;
			cnt_q <= '0;
			fin_q <= '0;
			mstep_q <= '0;
		end else if (!step_done) begin
			mstep_q <= mstep_q + 2'd1;
		end else begin
			mstep_q <= '0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					lane_q <= '0;
					state_q <= S_APRE;
				end
				// A short block is always last and leaves the accumulators alone.
				S_APRE: state_q <= st.stripe ? S_APST : S_MRG;
				S_APST: begin
					lane_q <= lane_q + 2'd1;
					if (lane_q == 2'd3) state_q <= st.last ? S_MRG : S_IDLE;
					else state_q <= S_APRE;
				end
				S_MRG: begin
					cnt_q <= st.nbytes;
					fin_q <= '0;
					state_q <= st.has8 ? S_8A : (st.has4 ? S_4A :
						(st.nbytes != 2'd0 ? S_BYT : S_FIN));
				end
				S_8A: state_q <= S_8B;
				S_8B: state_q <= S_8C;
				S_8C: state_q <= st.has4 ? S_4A : (cnt_q != 2'd0 ? S_BYT : S_FIN);
				S_4A: state_q <= S_4B;
				S_4B: state_q <= S_4C;
				S_4C: state_q <= (cnt_q != 2'd0) ? S_BYT : S_FIN;
				S_BYT: begin
					cnt_q <= cnt_q - 2'd1;
					if (cnt_q == 2'd1) state_q <= S_FIN;
				end
				S_FIN: begin
					fin_q <= fin_q + 3'd1;
					if (fin_q == 3'd4) state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/sh64_dp.sv =====
module sh64_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [63:0]        lane_low,
	input  logic [63:0]        lane_high,
	input  logic [4:0]         byte_count,
	input  logic               last_block,
	input  sh64_pkg::cmd_t     cmd,
	output sh64_pkg::status_t  st,
	output logic [63:0]        hash_value
);
	logic [63:0] acc_q [4];
	logic [63:0] len_q, lo_q, hi_q, h_q, t_q, prod;
	logic [4:0]  n_q;
	logic        last_q, saw_q, stripe_q;
	logic [3:0]  p_q;
	logic [63:0] ma, mb, lane_in;
	logic [4:0]  n_eff;
	logic [127:0] both;
	logic [31:0] mx, my;
	logic [63:0] pp, m_q;

	function automatic logic [63:0] rol(input logic [63:0] v, input logic [5:0] s);
		return (v << s) | (v >> (7'd64 - {1'b0, s}));
	endfunction

	assign both = {hi_q, lo_q};
	assign n_eff = (!last_block || byte_count > 5'd16) ? 5'd16 : byte_count;
	assign lane_in = cmd.lane[0] ? hi_q : lo_q;

	always_comb begin
		ma = h_q;
		mb = sh64_pkg::KEY3;
		case (cmd.op)
			sh64_pkg::OP_ACCPRE: begin
				ma = acc_q[cmd.lane] + lane_in;
				case (cmd.lane)
					2'd0: mb = sh64_pkg::KEY3;
					2'd1: mb = sh64_pkg::KEY2;
					2'd2: mb = sh64_pkg::KEY4;
					default: mb = sh64_pkg::KEY1;
				endcase
			end
			sh64_pkg::OP_ACCPOST: begin
				case (cmd.lane)
					2'd0: begin ma = rol(t_q, 6'd13); mb = sh64_pkg::KEY4; end
					2'd1: begin ma = rol(t_q, 6'd11); mb = sh64_pkg::KEY1; end
					2'd2: begin ma = rol(t_q, 6'd17); mb = sh64_pkg::KEY3; end
					default: begin ma = rol(t_q, 6'd19); mb = sh64_pkg::KEY2; end
				endcase
			end
			sh64_pkg::OP_C8PRE: begin ma = lo_q; mb = sh64_pkg::KEY3; end
			sh64_pkg::OP_C8POST: begin ma = rol(t_q, 6'd23); mb = sh64_pkg::KEY4; end
			sh64_pkg::OP_C8MIX: begin
				ma = rol(h_q ^ t_q, 6'd19); mb = sh64_pkg::KEY1;
			end
			sh64_pkg::OP_C4PRE: begin
				ma = {32'd0, both[{p_q, 3'b000} +: 32]}; mb = sh64_pkg::SKEY1;
			end
			sh64_pkg::OP_C4POST: begin ma = rol(t_q, 6'd17); mb = sh64_pkg::SKEY2; end
			sh64_pkg::OP_C4MIX: begin
				ma = rol(h_q ^ t_q, 6'd13); mb = sh64_pkg::SKEY3;
			end
			sh64_pkg::OP_BYTE: begin
				ma = {56'd0, both[{p_q, 3'b000} +: 8]}; mb = sh64_pkg::KEY3;
			end
			sh64_pkg::OP_FIN: begin
				ma = cmd.fin_step[1] ? (h_q ^ (h_q >> 31)) : (h_q ^ (h_q >> 29));
				mb = cmd.fin_step[1] ? sh64_pkg::KEY4 : sh64_pkg::KEY3;
			end
			default: ;
		endcase
	end

	// Low 64 bits of ma * mb built in steps: the low product, then the
	// two cross products added in at bit 32. Operands hold until the write.
	assign mx = (cmd.mstep == 2'd2) ? ma[63:32] : ma[31:0];
	assign my = (cmd.mstep == 2'd1) ? mb[63:32] : mb[31:0];
	assign pp = 64'(mx) * 64'(my);
	assign prod = m_q + {pp[31:0], 32'd0};

	always_ff @(posedge clk) begin
		m_q <= (cmd.mstep == 2'd0) ? pp : prod;
		if (cmd.wr) begin
			case (cmd.op)
				sh64_pkg::OP_LOAD: begin
					lo_q <= lane_low; hi_q <= lane_high; n_q <= n_eff;
					last_q <= last_block; stripe_q <= (n_eff == 5'd16);
					p_q <= '0;
				end
				sh64_pkg::OP_ACCPRE, sh64_pkg::OP_C8PRE, sh64_pkg::OP_C4PRE: t_q <= prod;
				sh64_pkg::OP_C8POST, sh64_pkg::OP_C4POST: t_q <= prod;
				sh64_pkg::OP_MERGE: h_q <= (saw_q ? (rol(acc_q[0], 6'd1)
					+ rol(acc_q[1], 6'd7) + rol(acc_q[2], 6'd12) + rol(acc_q[3], 6'd18))
					: (sh64_pkg::KEY1 + sh64_pkg::KEY3)) + len_q;
				sh64_pkg::OP_C8MIX: begin h_q <= prod + sh64_pkg::KEY2; p_q <= 4'd8; end
				sh64_pkg::OP_C4MIX: begin
					h_q <= prod + sh64_pkg::SKEY4; p_q <= p_q + 4'd4;
				end
				sh64_pkg::OP_BYTE: begin
					h_q <= rol(h_q ^ prod, 6'd37); p_q <= p_q + 4'd1;
				end
				sh64_pkg::OP_FIN: begin
					case (cmd.fin_step)
						3'd0, 3'd2: t_q <= prod;
						3'd1: h_q <= t_q;
						3'd3: h_q <= t_q;
						default: h_q <= h_q ^ (h_q >> 27);
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q[0] <= sh64_pkg::KEY1 ^ sh64_pkg::KEY3;
			acc_q[1] <= sh64_pkg::KEY2 ^ sh64_pkg::KEY4;
			acc_q[2] <= sh64_pkg::KEY3 ^ sh64_pkg::KEY2;
			acc_q[3] <= sh64_pkg::KEY4 ^ sh64_pkg::KEY1;
			len_q <= '0;
			saw_q <= 1'b0;
		end else if (cmd.wr) begin
			case (cmd.op)
				sh64_pkg::OP_LOAD: len_q <= len_q + {59'd0, n_eff};
				sh64_pkg::OP_ACCPOST: if (stripe_q) begin
					acc_q[cmd.lane] <= prod;
					saw_q <= 1'b1;
				end
				sh64_pkg::OP_RESET: begin
					acc_q[0] <= sh64_pkg::KEY1 ^ sh64_pkg::KEY3;
					acc_q[1] <= sh64_pkg::KEY2 ^ sh64_pkg::KEY4;
					acc_q[2] <= sh64_pkg::KEY3 ^ sh64_pkg::KEY2;
					acc_q[3] <= sh64_pkg::KEY4 ^ sh64_pkg::KEY1;
					len_q <= '0;
					saw_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign st.stripe = stripe_q;
	assign st.last   = last_q;
	assign st.has8   = !stripe_q && n_q[3];
	assign st.has4   = !stripe_q && n_q[2];
	assign st.nbytes = stripe_q ? 2'd0 : n_q[1:0];
	assign hash_value = h_q;
endmodule

// ===== rtl/stripe_hash_64_top.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    lane_low, lane_high, byte_count, last_block
// out      output     out_valid / out_ready  hash_value
//
// A full-stripe request keeps in_ready low after it is taken while it runs two
// multiplies per accumulator, each on the one shared 32x32 multiplier.
// A last request adds a merge step, pre, post and mix steps per 8- and 4-byte
// chunk, a multiply per tail byte and the finalizer; a short last request skips
// the accumulators. The hash then waits in its register until out_ready.
// Reset loads the keyed accumulators at once; once the hash is taken the state
// returns to reset and in_ready rises in the next cycle.
module stripe_hash_64_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] lane_low,
	input  logic [63:0] lane_high,
	input  logic [4:0]  byte_count,
	input  logic        last_block,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_value
);
	sh64_pkg::cmd_t    cmd;
	sh64_pkg::status_t st;

	// The controller sequences every request through the shared multiplier.
	sh64_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .st(st), .cmd(cmd)
	);

	// The datapath holds accumulators, length, and the running hash.
	sh64_dp u_dp (
		.clk(clk), .arst_n(arst_n), .lane_low(lane_low), .lane_high(lane_high),
		.byte_count(byte_count), .last_block(last_block), .cmd(cmd), .st(st),
		.hash_value(hash_value)
	);

`ifndef NO_ASSERTIONS
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hash_value))
		else $error("result lost");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready) else $error("no return to idle");
`endif
endmodule

// ===== tb/stripe_hash_64_top_test.sv =====
module stripe_hash_64_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Clock, reset and the ports of the block.
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] lane_low;
	logic [63:0] lane_high;
	logic [4:0]  byte_count;
	logic        last_block;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] hash_value;

	stripe_hash_64_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.lane_low(lane_low), .lane_high(lane_high),
		.byte_count(byte_count), .last_block(last_block),
		.out_valid(out_valid), .out_ready(out_ready),
		.hash_value(hash_value)
	);

	// The clock runs at a 12 ns period.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The digest model keeps its own copy of the accumulators, the running
	// length and the flag that tells whether any full stripe was absorbed.
	logic [63:0] acc [4];
	logic [63:0] msg_len;
	logic        stripe_seen;

	// Digests still owed by the block, oldest first.
	logic [63:0] digest_queue [$];
	int          fail_count;
	// When set, both sides stop idling so a long burst runs at full rate.
	bit          no_idle;
	// Set when the sender begins to wait for every owed digest.
	bit          paused;

	function automatic logic [63:0] rotl(input logic [63:0] v, input int s);
		rotl = (s % 64 == 0) ? v : ((v << (s % 64)) | (v >> (64 - s % 64)));
	endfunction

	function automatic logic [63:0] lane_byte(input logic [63:0] lo, input logic [63:0] hi,
			input int i);
		logic [63:0] w;
		w = (i < 8) ? lo : hi;
		lane_byte = (w >> ((i % 8) * 8)) & 64'hFF;
	endfunction

	task automatic digest_reset();
		acc[0] = sh64_pkg::KEY1 ^ sh64_pkg::KEY3;
		acc[1] = sh64_pkg::KEY2 ^ sh64_pkg::KEY4;
		acc[2] = sh64_pkg::KEY3 ^ sh64_pkg::KEY2;
		acc[3] = sh64_pkg::KEY4 ^ sh64_pkg::KEY1;
		msg_len = '0;
		stripe_seen = 1'b0;
	endtask

	// Advances the model by one request; a last request pushes its digest.
	task automatic digest_absorb(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] cnt, input logic lst);
		int          n;
		int          p;
		logic [63:0] h;
		logic [63:0] c;
		n = cnt;
		p = 0;
		if (n > 16 || !lst)
			n = 16;
		msg_len += 64'(n);
		if (n == 16) begin
			acc[0] = rotl((acc[0] + lo) * sh64_pkg::KEY3, 13) * sh64_pkg::KEY4;
			acc[1] = rotl((acc[1] + hi) * sh64_pkg::KEY2, 11) * sh64_pkg::KEY1;
			acc[2] = rotl((acc[2] + lo) * sh64_pkg::KEY4, 17) * sh64_pkg::KEY3;
			acc[3] = rotl((acc[3] + hi) * sh64_pkg::KEY1, 19) * sh64_pkg::KEY2;
			stripe_seen = 1'b1;
			n = 0;
		end
		if (!lst)
			return;
		if (stripe_seen)
			h = rotl(acc[0], 1) + rotl(acc[1], 7) + rotl(acc[2], 12) + rotl(acc[3], 18);
		else
			h = sh64_pkg::KEY1 + sh64_pkg::KEY3;
		h += msg_len;
		if (n - p >= 8) begin
			c = rotl(lo * sh64_pkg::KEY3, 23) * sh64_pkg::KEY4;
			h ^= c;
			h = rotl(h, 19) * sh64_pkg::KEY1 + sh64_pkg::KEY2;
			p += 8;
		end
		if (n - p >= 4) begin
			c = '0;
			for (int k = 0; k < 4; k++)
				c |= lane_byte(lo, hi, p + k) << (8 * k);
			c = rotl(c * sh64_pkg::SKEY1, 17) * sh64_pkg::SKEY2;
			h ^= c;
			h = rotl(h, 13) * sh64_pkg::SKEY3 + sh64_pkg::SKEY4;
			p += 4;
		end
		while (p < n) begin
			h ^= lane_byte(lo, hi, p) * sh64_pkg::KEY3;
			h = rotl(h, 37);
			p++;
		end
		h ^= h >> 29;
		h *= sh64_pkg::KEY3;
		h ^= h >> 31;
		h *= sh64_pkg::KEY4;
		h ^= h >> 27;
		digest_queue.push_back(h);
		digest_reset();
	endtask

	// Sends one request: optional idle cycles first, then valid is held until
	// the handshake completes. Valid is lowered only when no request follows
	// directly, so it never toggles twice in one time step.
	task automatic send_request(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] cnt, input logic lst);
		while (!no_idle && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		lane_low <= lo;
		lane_high <= hi;
		byte_count <= cnt;
		last_block <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		digest_absorb(lo, hi, cnt, lst);
	endtask

	// The receiver stalls at random except during the no-idle stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= 38);
		end
	end

	// Each accepted digest is compared with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (digest_queue.size() == 0) begin
				$display("%0t: unexpected digest, expected none, actual %h", $realtime,
					hash_value);
				fail_count++;
			end else begin
				if (hash_value !== digest_queue[0]) begin
					$display("%0t: hash_value mismatch, expected %h, actual %h", $realtime,
						digest_queue[0], hash_value);
					fail_count++;
				end
				void'(digest_queue.pop_front());
			end
		end
	end

	// Directed table. The first two rows hash the empty message from reset,
	// whose digest is known directly; that value is checked against the
	// model before the block's output is compared with the model.
	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  cnt;
		logic        lst;
	} request_row_t;

	request_row_t directed [] = '{
		// Empty message right after reset.
		'{64'h0, 64'h0, 5'd0, 1'b1},
		// Empty message with junk lanes: bytes beyond the count are ignored.
		'{'1, '1, 5'd0, 1'b1},
		// Single byte, three bytes, four-byte chunk, eight-byte chunk.
		'{64'hFF, 64'h0, 5'd1, 1'b1},
		'{64'h0000_0000_00AB_CDEF, '1, 5'd3, 1'b1},
		'{64'hFFFF_FFFF_DEAD_BEEF, '1, 5'd4, 1'b1},
		'{'1, '1, 5'd8, 1'b1},
		// Every tail piece at once, then the longest tail.
		'{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd15, 1'b1},
		'{'1, '1, 5'd15, 1'b1},
		// Last block of exactly sixteen bytes is a full stripe.
		'{64'h0, 64'h0, 5'd16, 1'b1},
		'{'1, '1, 5'd16, 1'b1},
		// Oversized counts on a last block act as sixteen.
		'{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 5'd17, 1'b1},
		'{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 5'd31, 1'b1},
		// Non-last short blocks are taken as sixteen bytes.
		'{'1, 64'h0, 5'd0, 1'b0},
		'{64'h0, '1, 5'd5, 1'b0},
		'{64'h1, 64'h2, 5'd31, 1'b0},
		'{64'h3, 64'h4, 5'd12, 1'b1},
		// A stripe followed by an empty last block.
		'{64'h8000_0000_0000_0000, 64'h1, 5'd16, 1'b0},
		'{64'h0, 64'h0, 5'd0, 1'b1},
		// Stripes with a short tail.
		'{'1, '1, 5'd16, 1'b0},
		'{'1, '1, 5'd16, 1'b0},
		'{64'h0000_0000_0000_0077, 64'h0, 5'd7, 1'b1}
	};

	// Digest of the zero-length message: the fixed constant plus length zero
	// through the finalizer.
	function automatic logic [63:0] empty_digest();
		logic [63:0] h;
		h = sh64_pkg::KEY1 + sh64_pkg::KEY3;
		h ^= h >> 29;
		h *= sh64_pkg::KEY3;
		h ^= h >> 31;
		h *= sh64_pkg::KEY4;
		h ^= h >> 27;
		empty_digest = h;
	endfunction

	function automatic logic [4:0] random_tail_count();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			random_tail_count = 5'($urandom_range(31, 17));
		else
			random_tail_count = 5'($urandom_range(16));
	endfunction

	initial begin
		int       sent;
		int       stripes;
		int       wait_cycles;
		in_valid = 1'b0;
		lane_low = '0;
		lane_high = '0;
		byte_count = '0;
		last_block = 1'b0;
		fail_count = 0;
		no_idle = 1'b0;
		paused = 1'b0;
		arst_n = 1'b0;
		digest_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The first two rows hash the empty message, which has
		// a value known without running the model.
		foreach (directed[i]) begin
			send_request(directed[i].lo, directed[i].hi, directed[i].cnt, directed[i].lst);
			if (i < 2 && digest_queue[$] !== empty_digest()) begin
				$display("%0t: empty message model, expected %h, actual %h", $realtime,
					empty_digest(), digest_queue[$]);
				fail_count++;
			end
		end

		// Random part: mostly well-formed messages of a few stripes and a
		// tail, with some non-last requests of odd counts mixed in.
		sent = 0;
		while (sent < 1500) begin
			// One stretch runs with no idling on either side.
			no_idle = (sent >= 600 && sent < 800);
			// The sender holds off once until every digest has arrived.
			if (sent >= 1000 && !paused) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (digest_queue.size() != 0)
					@(posedge clk);
			end
			stripes = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3);
			for (int s = 0; s < stripes; s++) begin
				send_request({$urandom, $urandom}, {$urandom, $urandom},
					($urandom_range(4) == 0) ? 5'($urandom) : 5'd16, 1'b0);
				sent++;
			end
			send_request({$urandom, $urandom}, {$urandom, $urandom},
				random_tail_count(), 1'b1);
			sent++;
		end
		in_valid <= 1'b0;
		no_idle = 1'b0;

		// Drain the remaining digests, then let the pipeline settle.
		wait_cycles = 0;
		while (digest_queue.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (60) @(posedge clk);

		if (fail_count == 0 && digest_queue.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Safety net: the slowest correct run is well under this bound.
	initial begin
		#(12ns * 600000);
		$display("Verification failed");
		$finish;
	end
endmodule

// ===== stripe_hash_64_top.f =====
rtl/sh64_pkg.sv
rtl/sh64_ctrl.sv
rtl/sh64_dp.sv
rtl/stripe_hash_64_top.sv
tb/stripe_hash_64_top_test.sv
